// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock edge, off during reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Same check, but also live while reset is high.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== hw/rtl/swa_pkg.sv =====
// ----------------------------------------------------------------------------
// swa_pkg
// Types, constants and helper functions of the sweep hit to angle decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package swa_pkg;

   localparam int TICK_BITS     = 20;
   localparam int STATIONS      = 16;
   localparam int FRAC_BITS     = 16;
   localparam int CORDIC_STAGES = 16;
   localparam int SEP_BITS      = 20;
   localparam int OUT_BITS      = 20;
   localparam int K_BITS        = 26;
   localparam int ANG_W         = 24;
   localparam int SHIFT_W       = 5;
   localparam int ROUND_SH      = 41 - FRAC_BITS;

   localparam logic [SEP_BITS-1:0] SEP_RESET = SEP_BITS'(20000);

   typedef logic signed [ANG_W-1:0]    ang_type;
   typedef logic signed [OUT_BITS-1:0] out_type;

   typedef enum logic {
      MODE_ROTATE,
      MODE_VECTOR
   } cordic_mode_type;

   typedef struct packed {
      logic [3:0]           station;
      logic [TICK_BITS-1:0] first_hit;
      logic [TICK_BITS-1:0] second_hit;
   } req_type;

   typedef struct packed {
      logic    ok;
      out_type azimuth;
      out_type elevation;
   } rsp_type;

   // Data handed from cell to cell
   typedef struct packed {
      logic    ok;
      out_type az;
      ang_type x;
      ang_type y;
      ang_type z;
   } cell_type;

   localparam longint ROT_NUM   = 64'd55267482437635;
   localparam longint PI_Q30    = 64'd3373259426;
   localparam longint PI2_Q30   = 64'd1686629713;
   localparam longint PI3_Q30   = 64'd1124419809;
   localparam longint GAIN_Q30  = 64'd652032874;
   localparam logic [30:0] SQRT3_Q30 = 31'd1859775394;

   // Q30 constant rounded half up to the working fraction
   function automatic ang_type from_q30(longint v);
      return ang_type'((v + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS));
   endfunction

   localparam ang_type PI_Q     = from_q30(PI_Q30);
   localparam ang_type PI2_Q    = from_q30(PI2_Q30);
   localparam ang_type PI3_Q    = from_q30(PI3_Q30);
   localparam ang_type GAIN_Q   = from_q30(GAIN_Q30);
   localparam ang_type TWO_PI_Q = ang_type'(2 * PI_Q);
   localparam ang_type ONE_Q    = ang_type'(1 <<< FRAC_BITS);

   // Rotor constant 16*pi*2^40/period, rounded, per station
   localparam logic [K_BITS-1:0] K_ROM [16] = '{
      K_BITS'((ROT_NUM + 959000 / 2) / 959000), K_BITS'((ROT_NUM + 957000 / 2) / 957000),
      K_BITS'((ROT_NUM + 953000 / 2) / 953000), K_BITS'((ROT_NUM + 949000 / 2) / 949000),
      K_BITS'((ROT_NUM + 947000 / 2) / 947000), K_BITS'((ROT_NUM + 943000 / 2) / 943000),
      K_BITS'((ROT_NUM + 941000 / 2) / 941000), K_BITS'((ROT_NUM + 939000 / 2) / 939000),
      K_BITS'((ROT_NUM + 937000 / 2) / 937000), K_BITS'((ROT_NUM + 929000 / 2) / 929000),
      K_BITS'((ROT_NUM + 919000 / 2) / 919000), K_BITS'((ROT_NUM + 911000 / 2) / 911000),
      K_BITS'((ROT_NUM + 907000 / 2) / 907000), K_BITS'((ROT_NUM + 901000 / 2) / 901000),
      K_BITS'((ROT_NUM + 893000 / 2) / 893000), K_BITS'((ROT_NUM + 887000 / 2) / 887000)
   };

   localparam longint ATAN_Q30 [24] = '{
      843314857, 497837829, 263043837, 133525159, 67021687,
      33543516, 16775851, 8388437, 4194283, 2097149,
      1048576, 524288, 262144, 131072, 65536, 32768,
      16384, 8192, 4096, 2048, 1024, 512, 256, 128
   };

   // Elementary rotation angle of one CORDIC step
   function automatic ang_type atan_step(logic [SHIFT_W-1:0] i);
      return from_q30(ATAN_Q30[i]);
   endfunction

   // Saturate to the output field range
   function automatic out_type clamp_out(ang_type v);
      if (v > ang_type'(2 ** (OUT_BITS - 1) - 1))
         return out_type'(2 ** (OUT_BITS - 1) - 1);
      if (v < -ang_type'(2 ** (OUT_BITS - 1)))
         return out_type'(-(2 ** (OUT_BITS - 1)));
      return out_type'(v);
   endfunction

endpackage

// ===== hw/rtl/sweep_hits_to_angles.sv =====
// ----------------------------------------------------------------------------
// sweep_hits_to_angles
// Sweep hit pair to azimuth and elevation decoder, top level.
// ----------------------------------------------------------------------------
// The block takes one hit pair per clock while req_stall is low and returns
// one result per pair, in order. The pipeline has four front stages (order and
// check, rotor scaling multiply, modulo reduction, fold), a chain of 16 sine
// CORDIC cells, one sqrt(3) scaling stage and a chain of 16 arctangent CORDIC
// cells. Every stage holds one transaction and passes it on as soon as the
// next stage is empty or moving, so bubbles close up while the output is
// stalled and req_stall rises only when all stages are full.
// Pairs closer than min_separation give ok low and zero angles.
`timescale 1ns / 1ps

module sweep_hits_to_angles (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  swa_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output swa_pkg::rsp_type rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [1:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import swa_pkg::*;

   localparam int CHAIN = 2 * CORDIC_STAGES + 1;

   logic [SEP_BITS-1:0] min_sep_ff;
   logic [SEP_BITS-1:0] min_sep_in;
   logic                front_ready;

   // Links between chain elements: front, sine cells, scale, atan cells
   logic     link_valid [CHAIN];
   logic     link_ready [CHAIN];
   cell_type link_data  [CHAIN];

   // Register port, single register at address 0
   assign pready = 1'b1;
   assign prdata = {{(32 - SEP_BITS){1'b0}}, min_sep_ff};

   always_comb begin
      min_sep_in = min_sep_ff;
      if (psel && penable && pwrite && (paddr == 2'd0)) begin
         min_sep_in = pwdata[SEP_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_sep_ff <= SEP_RESET;
      end else begin
         min_sep_ff <= min_sep_in;
      end
   end

   assign req_stall = !front_ready;

   swa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .min_sep   (min_sep_ff),
      .in_valid  (req_valid),
      .in_ready  (front_ready),
      .in_data   (req_data),
      .out_valid (link_valid[0]),
      .out_ready (link_ready[0]),
      .out_data  (link_data[0])
   );

   // Sine rotation cells
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_sin
      swa_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .mode      (MODE_ROTATE),
         .stage     (5'(i)),
         .in_valid  (link_valid[i]),
         .in_ready  (link_ready[i]),
         .in_data   (link_data[i]),
         .out_valid (link_valid[i+1]),
         .out_ready (link_ready[i+1]),
         .out_data  (link_data[i+1])
      );
   end

   swa_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (link_valid[CORDIC_STAGES]),
      .in_ready  (link_ready[CORDIC_STAGES]),
      .in_data   (link_data[CORDIC_STAGES]),
      .out_valid (link_valid[CORDIC_STAGES+1]),
      .out_ready (link_ready[CORDIC_STAGES+1]),
      .out_data  (link_data[CORDIC_STAGES+1])
   );

   // Arctangent vectoring cells; the last one is the output register
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_atan
      logic     o_valid;
      logic     o_ready;
      cell_type o_data;

      swa_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .mode      (MODE_VECTOR),
         .stage     (5'(i)),
         .in_valid  (link_valid[CORDIC_STAGES+1+i]),
         .in_ready  (link_ready[CORDIC_STAGES+1+i]),
         .in_data   (link_data[CORDIC_STAGES+1+i]),
         .out_valid (o_valid),
         .out_ready (o_ready),
         .out_data  (o_data)
      );

      if (i < CORDIC_STAGES - 1) begin : g_mid
         assign link_valid[CORDIC_STAGES+2+i] = o_valid;
         assign link_data[CORDIC_STAGES+2+i]  = o_data;
         assign o_ready = link_ready[CORDIC_STAGES+2+i];
      end else begin : g_last
         assign rsp_valid = o_valid;
         assign o_ready   = !rsp_stall;
         // Failed transactions report zero angles
         always_comb begin
            rsp_data.ok        = o_data.ok;
            rsp_data.azimuth   = o_data.ok ? o_data.az : '0;
            rsp_data.elevation = o_data.ok ? clamp_out(o_data.z) : '0;
         end
      end
   end

endmodule

// ===== hw/rtl/swa_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// swa_cordic_cell
// One CORDIC micro-rotation with its own pipeline register and handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swa_cordic_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  swa_pkg::cordic_mode_type mode,
   input  logic [4:0]               stage,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  swa_pkg::cell_type        in_data,
   output logic                     out_valid,
   input  logic                     out_ready,
   output swa_pkg::cell_type        out_data
);
   import swa_pkg::*;

   logic     valid_ff;
   cell_type data_ff;
   cell_type data_in;
   ang_type  dx;
   ang_type  dy;
   ang_type  a;
   logic     pos;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // Micro-rotation; shifts floor toward minus infinity
   always_comb begin
      dx  = in_data.y >>> stage;
      dy  = in_data.x >>> stage;
      a   = atan_step(stage);
      pos = (mode == MODE_ROTATE) ? !in_data.z[ANG_W-1] : in_data.y[ANG_W-1];
      data_in = in_data;
      if (pos) begin
         data_in.x = in_data.x - dx;
         data_in.y = in_data.y + dy;
         data_in.z = in_data.z - a;
      end else begin
         data_in.x = in_data.x + dx;
         data_in.y = in_data.y - dy;
         data_in.z = in_data.z + a;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== hw/rtl/swa_front.sv =====
// ----------------------------------------------------------------------------
// swa_front
// Hit ordering, separation check, rotor scaling and angle range reduction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swa_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [swa_pkg::SEP_BITS-1:0]    min_sep,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  swa_pkg::req_type                in_data,
   output logic                            out_valid,
   input  logic                            out_ready,
   output swa_pkg::cell_type               out_data
);
   import swa_pkg::*;

   localparam int PROD_W = TICK_BITS + 1 + K_BITS;

   logic                 v0_ff, v1_ff, v2_ff, v3_ff;
   logic                 rdy0, rdy1, rdy2, rdy3;

   // stage 0
   logic                 ok0_ff;
   logic [TICK_BITS:0]   sum0_ff;
   logic [TICK_BITS-1:0] diff0_ff;
   logic [K_BITS-1:0]    k0_ff;
   logic [TICK_BITS-1:0] lo, hi, diff;
   logic [3:0]           st;

   // stage 1
   logic                 ok1_ff;
   logic [PROD_W-ROUND_SH-1:0]   mean1_ff;
   logic [PROD_W-ROUND_SH-2:0]   half1_ff;
   logic [PROD_W-1:0]    prod_sum;
   logic [PROD_W-2:0]    prod_diff;

   // stage 2
   logic                 ok2_ff;
   out_type              az2_ff;
   ang_type              r2_ff;
   ang_type              half, r, az_full;

   // stage 3
   cell_type             c3_ff;
   ang_type              f;

   assign rdy3      = !v3_ff || out_ready;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign rdy0      = !v0_ff || rdy1;
   assign in_ready  = rdy0;
   assign out_valid = v3_ff;
   assign out_data  = c3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy0) v0_ff <= in_valid;
         if (rdy1) v1_ff <= v0_ff;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   // Order the hits, check separation, pick the rotor constant
   always_comb begin
      if (in_data.first_hit > in_data.second_hit) begin
         lo = in_data.second_hit;
         hi = in_data.first_hit;
      end else begin
         lo = in_data.first_hit;
         hi = in_data.second_hit;
      end
      diff = hi - lo;
      if ({1'b0, in_data.station} >= 5'(STATIONS)) begin
         st = 4'(STATIONS - 1);
      end else begin
         st = in_data.station;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy0 && in_valid) begin
         ok0_ff   <= (diff >= min_sep);
         sum0_ff  <= {1'b0, lo} + {1'b0, hi};
         diff0_ff <= diff;
         k0_ff    <= K_ROM[st];
      end
   end

   // Scale to rotor angles, round to the working fraction
   always_comb begin
      prod_sum  = PROD_W'(sum0_ff) * PROD_W'(k0_ff);
      prod_diff = (PROD_W - 1)'(diff0_ff) * (PROD_W - 1)'(k0_ff);
   end

   always_ff @(posedge clock) begin
      if (rdy1 && v0_ff) begin
         ok1_ff   <= ok0_ff;
         mean1_ff <= (PROD_W - ROUND_SH)'((prod_sum + (PROD_W'(1) << (ROUND_SH - 1)))
                     >> ROUND_SH);
         half1_ff <= (PROD_W - ROUND_SH - 1)'((prod_diff
                     + ((PROD_W - 1)'(1) << (ROUND_SH - 1))) >> ROUND_SH);
      end
   end

   // Azimuth and modulo 2*pi of the half spread (quotient at most seven)
   always_comb begin
      az_full = ang_type'(mean1_ff) - PI_Q;
      half    = ang_type'(half1_ff) - PI3_Q;
      r       = half;
      if (half < 0) begin
         r = half + TWO_PI_Q;
      end else begin
         if (r >= ang_type'(4 * TWO_PI_Q)) r = r - ang_type'(4 * TWO_PI_Q);
         if (r >= ang_type'(2 * TWO_PI_Q)) r = r - ang_type'(2 * TWO_PI_Q);
         if (r >= TWO_PI_Q)                r = r - TWO_PI_Q;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy2 && v1_ff) begin
         ok2_ff <= ok1_ff;
         az2_ff <= clamp_out(az_full);
         r2_ff  <= r;
      end
   end

   // Fold into [-pi, pi], then into [-pi/2, pi/2]
   always_comb begin
      f = r2_ff;
      if (f > PI_Q) f = f - TWO_PI_Q;
      if (f > PI2_Q) begin
         f = PI_Q - f;
      end else if (f < -PI2_Q) begin
         f = -PI_Q - f;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3 && v2_ff) begin
         c3_ff.ok <= ok2_ff;
         c3_ff.az <= az2_ff;
         c3_ff.x  <= GAIN_Q;
         c3_ff.y  <= '0;
         c3_ff.z  <= f;
      end
   end

endmodule

// ===== hw/rtl/swa_scale.sv =====
// ----------------------------------------------------------------------------
// swa_scale
// Multiplies the sine by sqrt(3) and seeds the arctangent cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swa_scale (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  swa_pkg::cell_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output swa_pkg::cell_type out_data
);
   import swa_pkg::*;

   localparam int MAG_W = FRAC_BITS + 2;
   localparam int PRD_W = MAG_W + 31;

   logic              valid_ff;
   cell_type          data_ff;
   ang_type           s_abs;
   logic [MAG_W-1:0]  mag;
   logic [PRD_W-1:0]  prod;
   ang_type           y0;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // |sin| * sqrt(3), rounded half away from zero
   always_comb begin
      s_abs = in_data.y[ANG_W-1] ? -in_data.y : in_data.y;
      mag   = s_abs[MAG_W-1:0];
      prod  = PRD_W'(mag) * PRD_W'(SQRT3_Q30);
      y0    = ang_type'((prod + (PRD_W'(1) << 29)) >> 30);
      if (in_data.y[ANG_W-1]) y0 = -y0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff.ok <= in_data.ok;
         data_ff.az <= in_data.az;
         data_ff.x  <= ONE_Q;
         data_ff.y  <= y0;
         data_ff.z  <= '0;
      end
   end

endmodule

// ===== hw/rtl/swa_checker.sv =====
// ----------------------------------------------------------------------------
// swa_checker
// Port-level assertions for the sweep hit decoder, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module swa_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input swa_pkg::rsp_type rsp_data,
   input logic             psel,
   input logic             penable,
   input logic             pwrite,
   input logic [1:0]       paddr,
   input logic [31:0]      pwdata,
   input logic [31:0]      prdata,
   input logic             pready
);
   import swa_pkg::*;

   // Too-close hits carry zero angles
   `ASSERT_CLK(a_fail_zero, rsp_valid && !rsp_data.ok |-> rsp_data.azimuth == 0 && rsp_data.elevation == 0, "failed transaction with nonzero angles")

   // Elevation stays near [-pi/2, pi/2]
   `ASSERT_CLK(a_elev_range, rsp_valid && rsp_data.ok |-> rsp_data.elevation <= out_type'(120000) && rsp_data.elevation >= -out_type'(120000), "elevation out of range")

   // A stalled result holds
   `ASSERT_CLK(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "stalled result changed")

   // Register write is read back on the next cycle
   `ASSERT_CLK(a_csr_write, psel && penable && pwrite && paddr == 2'd0 |=> prdata == {12'd0, $past(pwdata[19:0])}, "register readback mismatch")

   // The register port never waits
   `ASSERT_ALWAYS(a_pready, pready, "pready low")

endmodule

bind sweep_hits_to_angles swa_checker u_swa_checker (.*);

// ===== bench/sweep_hits_to_angles_test.sv =====
// ----------------------------------------------------------------------------
// sweep_hits_to_angles_test
// Self-checking bench for the sweep hit pair to angle decoder. Hit pairs are
// sent with random gaps and the result side stalls at random. Every result is
// compared with a bit-accurate software copy of the fixed-point CORDIC math.
// min_separation is swept through its reset value, both extremes and random
// values between result-free pauses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sweep_hits_to_angles_test;
   import swa_pkg::*;

   // Constants; the _30 ones are fixed point with 30 fraction bits
   localparam longint ROTOR_NUM = 64'sd55267482437635;
   localparam longint PI_30     = 64'sd3373259426;
   localparam longint HALF_PI_30 = 64'sd1686629713;
   localparam longint THIRD_PI_30 = 64'sd1124419809;
   localparam longint ROOT3_30  = 64'sd1859775394;
   localparam longint GAIN_30   = 64'sd652032874;
   localparam longint SAT_HI    = 64'sd524287;
   localparam longint SAT_LO    = -64'sd524288;
   localparam int     FRAC      = 16;
   localparam int     STAGES    = 16;
   localparam int     DRAIN_CYCLES = 60;
   localparam int     WATCHDOG_LIMIT = 5000;

   localparam longint PERIODS [16] = '{
      959000, 957000, 953000, 949000, 947000, 943000, 941000, 939000,
      937000, 929000, 919000, 911000, 907000, 901000, 893000, 887000
   };
   localparam longint ARCTAN_30 [16] = '{
      843314857, 497837829, 263043837, 133525159, 67021687,
      33543516, 16775851, 8388437, 4194283, 2097149,
      1048576, 524288, 262144, 131072, 65536, 32768
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [1:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   rsp_type     expected_angles [$];
   longint      separation_setting;
   int          mismatches = 0;
   int          idle_cycles = 0;
   bit          steady_flow = 1'b0;

   sweep_hits_to_angles dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #5 clock = ~clock;

   // Round a 30-fraction-bit constant half up to the working fraction
   function automatic longint q30_round(longint v);
      return (v + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
   endfunction

   function automatic longint saturate(longint v);
      if (v > SAT_HI) return SAT_HI;
      if (v < SAT_LO) return SAT_LO;
      return v;
   endfunction

   // Expected azimuth and elevation of one hit pair
   function automatic rsp_type predict_angles(req_type r);
      rsp_type res;
      longint lo, hi, t, d, k, rnd, mean, half, ang, pi, hpi, two_pi;
      longint x, y, z, dx, dy, a, s, mag, y0;
      lo = r.first_hit;
      hi = r.second_hit;
      res = '0;
      if (lo > hi) begin
         t = lo; lo = hi; hi = t;
      end
      d = hi - lo;
      if (d < separation_setting) return res;
      pi = q30_round(PI_30);
      hpi = q30_round(HALF_PI_30);
      two_pi = 2 * pi;
      k = (ROTOR_NUM + PERIODS[r.station] / 2) / PERIODS[r.station];
      rnd = 64'sd1 <<< (40 - FRAC);
      mean = ((lo + hi) * k + rnd) >>> (41 - FRAC);
      half = ((d * k + rnd) >>> (41 - FRAC)) - q30_round(THIRD_PI_30);
      // reduce to [-pi, pi], fold into [-pi/2, pi/2]
      ang = half % two_pi;
      if (ang < 0) ang += two_pi;
      if (ang > pi) ang -= two_pi;
      if (ang > hpi) ang = pi - ang;
      else if (ang < -hpi) ang = -pi - ang;
      // rotation mode: sine of the half spread
      x = q30_round(GAIN_30); y = 0; z = ang;
      for (int i = 0; i < STAGES; i++) begin
         dx = y >>> i; dy = x >>> i; a = q30_round(ARCTAN_30[i]);
         if (z >= 0) begin
            x -= dx; y += dy; z -= a;
         end else begin
            x += dx; y -= dy; z += a;
         end
      end
      s = y;
      mag = (s < 0) ? -s : s;
      y0 = (mag * ROOT3_30 + (64'sd1 <<< 29)) >>> 30;
      if (s < 0) y0 = -y0;
      // vectoring mode: arctangent of y0
      x = 64'sd1 <<< FRAC; y = y0; z = 0;
      for (int i = 0; i < STAGES; i++) begin
         dx = y >>> i; dy = x >>> i; a = q30_round(ARCTAN_30[i]);
         if (y >= 0) begin
            x += dx; y -= dy; z += a;
         end else begin
            x -= dx; y += dy; z -= a;
         end
      end
      res.ok = 1'b1;
      res.azimuth = out_type'(saturate(mean - pi));
      res.elevation = out_type'(saturate(z));
      return res;
   endfunction

   // Gap length: mostly none or short, sometimes long
   function automatic int gap_length();
      int p;
      if (steady_flow) return 0;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Send one hit pair and record its expected result on acceptance
   task automatic send_pair(req_type r);
      int gap;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      expected_angles.push_back(predict_angles(r));
      gap = gap_length();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic send_hits(int st, longint a, longint b);
      req_type r;
      r.station = 4'(st);
      r.first_hit = TICK_BITS'(a);
      r.second_hit = TICK_BITS'(b);
      send_pair(r);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_angles.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write min_separation while idle, then read it back
   task automatic write_separation(longint value);
      wait_drained();
      @(negedge clock);
      psel <= 1'b1; pwrite <= 1'b1; paddr <= '0; pwdata <= 32'(value);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      separation_setting = value & 64'hFFFFF;
      @(negedge clock);
      penable <= 1'b0; pwrite <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[SEP_BITS-1:0] !== SEP_BITS'(separation_setting)) begin
         mismatches++;
         if (mismatches <= 10)
            $display("csr readback: expected %0d got %0d", separation_setting, prdata);
      end
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0;
   endtask

   task automatic send_random_pairs(int count);
      longint a, d;
      for (int n = 0; n < count; n++) begin
         a = $urandom_range(0, 20'hFFFFF);
         case ($urandom_range(0, 3))
            0: d = $urandom_range(0, 20'hFFFFF);
            1: d = separation_setting + $urandom_range(0, 4) - 2;
            default: d = separation_setting + $urandom_range(0, 400000);
         endcase
         if ($urandom_range(0, 1)) send_hits($urandom_range(0, 15), a, a + d);
         else send_hits($urandom_range(0, 15), a + d, a);
      end
   endtask

   // Reset value: boundary around 20000, both orders, extremes
   task automatic test_reset_separation();
      send_hits(0, 1000, 1000);
      send_hits(0, 0, 19999);
      send_hits(0, 0, 20000);
      send_hits(15, 20000, 0);
      send_hits(15, 0, 20'hFFFFF);
      send_hits(7, 20'hFFFFF, 0);
      send_hits(3, 20'hFFFFF, 20'hFFFFF);
      send_hits(9, 500000, 900000);
   endtask

   // Every station at a mid-range spread
   task automatic test_all_stations();
      for (int st = 0; st < 16; st++) send_hits(st, 100000 + st * 7, 260000 + st * 1000);
   endtask

   // Zero separation: equal hits become valid
   task automatic test_zero_separation();
      write_separation(0);
      send_hits(4, 0, 0);
      send_hits(5, 20'hFFFFF, 20'hFFFFF);
      send_hits(6, 1, 0);
      send_random_pairs(100);
   endtask

   // Largest separation: only the full span passes
   task automatic test_max_separation();
      write_separation(20'hFFFFF);
      send_hits(1, 0, 20'hFFFFF);
      send_hits(2, 20'hFFFFF, 0);
      send_hits(2, 1, 20'hFFFFF);
      send_random_pairs(40);
   endtask

   // Random traffic over several settings, with a full drain and a
   // stretch of unbroken flow
   task automatic test_random_traffic();
      write_separation(20000);
      send_random_pairs(300);
      wait_drained();
      steady_flow = 1'b1;
      send_random_pairs(200);
      steady_flow = 1'b0;
      for (int p = 0; p < 4; p++) begin
         write_separation($urandom_range(0, 300000));
         send_random_pairs(200);
      end
   endtask

   // Result-side stall pattern
   initial begin
      int run;
      forever begin
         @(negedge clock);
         if (steady_flow) begin
            rsp_stall <= 1'b0;
         end else begin
            run = gap_length();
            if (run > 0) begin
               rsp_stall <= 1'b1;
               repeat (run - 1) @(negedge clock);
               @(negedge clock);
            end
            rsp_stall <= 1'b0;
            repeat ($urandom_range(0, 8)) @(negedge clock);
         end
      end
   end

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_angles.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transaction %h", rsp_data);
         end else begin
            want = expected_angles.pop_front();
            if (rsp_data.ok !== want.ok || rsp_data.azimuth !== want.azimuth ||
                rsp_data.elevation !== want.elevation) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected ok=%0d az=%0d el=%0d, got ok=%0d az=%0d el=%0d",
                           want.ok, want.azimuth, want.elevation,
                           rsp_data.ok, rsp_data.azimuth, rsp_data.elevation);
            end
         end
      end
   end

   // Watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      separation_setting = 20000;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_separation();
      test_all_stations();
      test_zero_separation();
      test_max_separation();
      test_random_traffic();
      wait_drained();
      if (mismatches == 0 && expected_angles.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
